[hdl/sacwt_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants and helpers of the write-through cache.
package sacwt_pkg;
  localparam int unsigned AddrBits  = 20;
  localparam int unsigned Ways      = 8;
  localparam int unsigned Sets      = 128;
  localparam int unsigned LineBytes = 64;

  localparam int unsigned OffBits  = $clog2(LineBytes);
  localparam int unsigned SetBits  = $clog2(Sets);
  localparam int unsigned WayBits  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned TagBits  = AddrBits - OffBits - SetBits;
  localparam int unsigned LineIdxBits = SetBits + WayBits;
  localparam int unsigned ByteIdxBits = LineIdxBits + OffBits;
  localparam int unsigned MemDepth = 2 ** AddrBits;
  localparam int unsigned Lines    = Sets * Ways;

  localparam logic [15:0] LfsrTaps  = 16'hB400;
  localparam logic [15:0] SeedReset = 16'd44257;

  typedef struct packed {
    logic                is_write;
    logic [AddrBits-1:0] addr;
    logic [2:0]          len;
    logic [31:0]         wdata;
  } req_t;

  function automatic logic [15:0] lfsr_next(logic [15:0] v);
    logic [15:0] r;
    r = v >> 1;
    if (v[0]) r = r ^ LfsrTaps;
    return r;
  endfunction
endpackage

[hdl/sacwt_ram.sv]
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
module sacwt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[hdl/set_assoc_cache_write_through.sv]
`timescale 1ns / 1ps
// Top level of the write-through set-associative cache with its backing memory.
// One request is handled at a time by a sequencer around four synchronous memories:
// per-set valid flags, a tag RAM, a line-data RAM and the backing byte RAM. After
// reset a clearing pass zeroes the valid flags one set per cycle while the request
// input is held off. A request first searches the tags of its set way by way, each
// tag compared as it is read back, then accesses the requested bytes in turn; a
// read miss adds a line fill of one byte per cycle. The result is held in an
// output register and the next request is accepted once it is taken.
module set_assoc_cache_write_through
  import sacwt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [19:0] address, [22:20] access_length, [54:23] write_data, zero pad to 56
  input  logic [55:0] s_axis_tdata_i,
  // [0] req_type
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] read_data, [32] hit, zero pad to 40
  output logic [39:0] m_axis_tdata_o
);
  localparam logic [2:0] StIdle = 3'd0, StTag = 3'd1, StAcc = 3'd2,
                         StFill = 3'd3, StOut = 3'd4, StClr = 3'd5;

  logic [2:0] state_q, state_d;
  req_t       req_q;
  logic [15:0] lfsr_q;
  logic [SetBits-1:0] clr_q;     // set being cleared after reset
  logic [WayBits:0] wcnt_q;      // way counter for search
  logic [OffBits:0] bcnt_q;      // byte / fill counter
  logic             found_q;
  logic [WayBits-1:0] way_q;
  logic [31:0] rdata_q;
  logic        hit_q;
  logic        out_valid_q;

  logic [OffBits-1:0] off;
  logic [SetBits-1:0] set_idx;
  logic [TagBits-1:0] tag;
  assign off     = req_q.addr[OffBits-1:0];
  assign set_idx = req_q.addr[OffBits +: SetBits];
  assign tag     = req_q.addr[AddrBits-1 -: TagBits];

  // valid RAM, one word of way flags per set
  logic                   v_we;
  logic [SetBits-1:0]     v_addr;
  logic [Ways-1:0]        v_wd, v_rd;
  // tag RAM
  logic                   tag_we;
  logic [LineIdxBits-1:0] tag_addr;
  logic [TagBits-1:0]     tag_rd;
  // line RAM
  logic                   ln_we;
  logic [ByteIdxBits-1:0] ln_addr;
  logic [7:0]             ln_wd, ln_rd;
  // backing RAM
  logic                   bm_we;
  logic [AddrBits-1:0]    bm_addr;
  logic [7:0]             bm_wd, bm_rd;

  sacwt_ram #(.Width(Ways), .Depth(Sets)) u_valid (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(v_wd), .rdata_o(v_rd));
  sacwt_ram #(.Width(TagBits), .Depth(Sets * (2 ** WayBits))) u_tag (
    .clk_i, .we_i(tag_we), .addr_i(tag_addr), .wdata_i(tag), .rdata_o(tag_rd));
  sacwt_ram #(.Width(8), .Depth(Sets * (2 ** WayBits) * LineBytes)) u_line (
    .clk_i, .we_i(ln_we), .addr_i(ln_addr), .wdata_i(ln_wd), .rdata_o(ln_rd));
  sacwt_ram #(.Width(8), .Depth(MemDepth)) u_mem (
    .clk_i, .we_i(bm_we), .addr_i(bm_addr), .wdata_i(bm_wd), .rdata_o(bm_rd));

  // search pipeline: address way wcnt, compare previous way in the next cycle
  logic [WayBits-1:0] cmp_way;
  logic               cmp_valid;
  logic [WayBits-1:0] vict;
  logic               any_inv;
  logic [15:0]        lfsr_nx;
  logic [2:0]         len_sat;
  logic [OffBits-1:0] cur_off;     // byte address being issued
  logic [1:0]         prev_k;

  assign len_sat  = (req_q.len > 3'd4) ? 3'd4 : req_q.len;
  assign cmp_way  = WayBits'(wcnt_q - 1'b1);
  assign cmp_valid = v_rd[cmp_way];
  assign lfsr_nx  = lfsr_next(lfsr_q);
  assign cur_off  = off + OffBits'(bcnt_q);
  assign prev_k   = 2'(bcnt_q - 1'b1);

  always_comb begin
    any_inv = 1'b0;
    vict    = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (!v_rd[WayBits'(w)]) begin
        any_inv = 1'b1;
        vict    = WayBits'(w);
      end
    end
  end

  always_comb begin
    v_we     = 1'b0;
    v_addr   = set_idx;
    v_wd     = v_rd | (Ways'(1) << way_q);
    tag_we   = 1'b0;
    tag_addr = {set_idx, wcnt_q[WayBits-1:0]};
    ln_we    = 1'b0;
    ln_addr  = {set_idx, way_q, cur_off};
    ln_wd    = req_q.wdata[8*bcnt_q[1:0] +: 8];
    bm_we    = 1'b0;
    bm_addr  = {req_q.addr[AddrBits-1:OffBits], cur_off};
    bm_wd    = req_q.wdata[8*bcnt_q[1:0] +: 8];
    state_d  = state_q;
    unique case (state_q)
      StClr: begin
        v_addr = clr_q;
        v_we   = 1'b1;
        v_wd   = '0;
        if (clr_q == SetBits'(Sets - 1)) state_d = StIdle;
      end
      StIdle: if (s_axis_tvalid_i) state_d = StTag;
      StTag: if (wcnt_q == (WayBits+1)'(Ways)) state_d = StAcc;
      StAcc: begin
        if (req_q.is_write) begin
          bm_we = bcnt_q < (OffBits+1)'(len_sat);
          ln_we = bm_we && found_q;
          if (!bm_we) state_d = StOut;
        end else begin
          if (bcnt_q == (OffBits+1)'(len_sat)) state_d = found_q ? StOut : StFill;
        end
      end
      StFill: begin
        // read byte bcnt, write byte bcnt-1 into the line
        bm_addr = {req_q.addr[AddrBits-1:OffBits], OffBits'(bcnt_q)};
        ln_addr = {set_idx, way_q, OffBits'(bcnt_q - 1'b1)};
        ln_wd   = bm_rd;
        ln_we   = bcnt_q != '0;
        tag_addr = {set_idx, way_q};
        tag_we   = bcnt_q == '0;
        v_we     = bcnt_q == '0;
        if (bcnt_q == (OffBits+1)'(LineBytes)) state_d = StOut;
      end
      StOut: if (m_axis_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      req_q   <= '0;
      lfsr_q  <= SeedReset;
      clr_q   <= '0;
      wcnt_q  <= '0;
      bcnt_q  <= '0;
      found_q <= 1'b0;
      way_q   <= '0;
      rdata_q <= '0;
      hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) lfsr_q <= (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
      unique case (state_q)
        StClr: clr_q <= clr_q + 1'b1;
        StIdle: begin
          wcnt_q  <= '0;
          bcnt_q  <= '0;
          found_q <= 1'b0;
          rdata_q <= '0;
          if (s_axis_tvalid_i) begin
            req_q <= '{is_write: s_axis_tuser_i, addr: s_axis_tdata_i[19:0],
                       len: s_axis_tdata_i[22:20], wdata: s_axis_tdata_i[54:23]};
          end
        end
        StTag: begin
          wcnt_q <= wcnt_q + 1'b1;
          if (wcnt_q != '0 && !found_q && cmp_valid && tag_rd == tag) begin
            found_q <= 1'b1;
            way_q   <= cmp_way;
          end
        end
        StAcc: begin
          if (!req_q.is_write && bcnt_q != '0) begin
            rdata_q[8*prev_k +: 8] <= found_q ? ln_rd : bm_rd;
          end
          if (state_d == StAcc) bcnt_q <= bcnt_q + 1'b1;
          else begin
            bcnt_q <= '0;
            if (state_d == StFill) begin
              if (any_inv) way_q <= vict;
              else begin
                way_q  <= lfsr_nx[WayBits-1:0];
                lfsr_q <= lfsr_nx;
              end
            end
          end
        end
        StFill: bcnt_q <= bcnt_q + 1'b1;
        default: ;
      endcase
      if (state_q != StOut && state_d == StOut) begin
        out_valid_q <= 1'b1;
        hit_q       <= found_q;
      end else if (state_q == StOut && m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = state_q == StIdle;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, hit_q, req_q.is_write ? 32'd0 : rdata_q};
endmodule
